@@ design/sbac_pkg.sv @@
// Shared types, codes and constants for the spectrum background adaptation check.
// Used by every module of the block; no dependencies.
`default_nettype none

package sbac_pkg;

  localparam int IDX_W  = 5;
  localparam int VAL_W  = 16;
  localparam int OUTC_W = 4;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int LIM_W  = 15;
  localparam int BAND_W = 8;

  // bins reachable by the index field
  localparam int WRITE_SPAN = 2 ** IDX_W;

  localparam int DEF_FRAME_BINS   = 32;
  localparam int DEF_COMPARE_BINS = 10;

  // item modes
  localparam logic [MODE_W-1:0] MODE_BASE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADAPT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRAME  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DECIDE = 2'd3;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUT_LOAD       = 4'd0;
  localparam logic [OUTC_W-1:0] OUT_UNARMED    = 4'd1;
  localparam logic [OUTC_W-1:0] OUT_TEMP_STBL  = 4'd2;
  localparam logic [OUTC_W-1:0] OUT_DIFF_HARD  = 4'd3;
  localparam logic [OUTC_W-1:0] OUT_ADAPT_HARD = 4'd4;
  localparam logic [OUTC_W-1:0] OUT_BASE_HARD  = 4'd5;
  localparam logic [OUTC_W-1:0] OUT_ADOPT_A    = 4'd6;
  localparam logic [OUTC_W-1:0] OUT_ADOPT_B    = 4'd7;
  localparam logic [OUTC_W-1:0] OUT_NONE       = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BAND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE = 2'd3;

  localparam logic [BAND_W-1:0] RST_TEMP_BAND  = 8'd8;
  localparam logic [LIM_W-1:0]  RST_HARD_LIMIT = 15'd32;
  localparam logic [LIM_W-1:0]  RST_SOFT_LIMIT = 15'd16;
  localparam logic [LIM_W-1:0]  RST_MIN_CHANGE = 15'd8;

  typedef struct packed {
    logic [BAND_W-1:0] temp_band;
    logic [LIM_W-1:0]  hard_limit;
    logic [LIM_W-1:0]  soft_limit;
    logic [LIM_W-1:0]  min_change;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] frame_diff;
    logic signed [VAL_W-1:0] frame_diff_alt;
    logic signed [VAL_W-1:0] base_diff;
    logic signed [VAL_W-1:0] base_diff_alt;
    logic signed [VAL_W-1:0] temperature;
    logic signed [VAL_W-1:0] vptat;
    logic                    armed;
  } decide_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] rise;
    logic signed [VAL_W-1:0] fall;
    logic signed [VAL_W-1:0] rise_base;
    logic signed [VAL_W-1:0] fall_base;
  } sums_t;

  typedef struct packed {
    logic frame;
    logic adapt;
    logic base;
  } store_we_t;

endpackage

`default_nettype wire

@@ design/sbac_bin_store.sv @@
// Bin memories: current frame, and a two-lane row holding adaptive and base background.
// One write and one read address per cycle, registered read data. Uses sbac_pkg.
`default_nettype none

module sbac_bin_store
  import sbac_pkg::*;
#(
  parameter int FRAME_BINS = DEF_FRAME_BINS
) (
  input  wire logic                     clk,
  input  wire store_we_t                we,
  input  wire logic [$clog2(FRAME_BINS)-1:0] waddr,
  input  wire logic [VAL_W-1:0]         wdata,
  input  wire logic [VAL_W-1:0]         adapt_wdata,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(FRAME_BINS)-1:0] raddr,
  output logic      [VAL_W-1:0]         frame_q,
  output logic      [VAL_W-1:0]         adapt_q,
  output logic      [VAL_W-1:0]         base_q
);

  logic [VAL_W-1:0]   frame_mem [FRAME_BINS];
  // low lane adaptive, high lane base
  logic [2*VAL_W-1:0] bg_mem    [FRAME_BINS];

  always_ff @(posedge clk) begin
    if (we.frame) begin
      frame_mem[waddr] <= wdata;
    end
    if (we.adapt) begin
      bg_mem[waddr][VAL_W-1:0] <= adapt_wdata;
    end
    if (we.base) begin
      bg_mem[waddr][2*VAL_W-1:VAL_W] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      frame_q <= frame_mem[raddr];
      adapt_q <= bg_mem[raddr][VAL_W-1:0];
      base_q  <= bg_mem[raddr][2*VAL_W-1:VAL_W];
    end
  end

endmodule

`default_nettype wire

@@ design/sbac_accum.sv @@
// Rise and fall accumulators of the frame against both backgrounds.
// One bin per cycle while en is high; sums wrap at 16 bits. Uses sbac_pkg.
`default_nettype none

module sbac_accum
  import sbac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             en,
  input  wire logic [VAL_W-1:0] frame_q,
  input  wire logic [VAL_W-1:0] adapt_q,
  input  wire logic [VAL_W-1:0] base_q,
  output sums_t                 sums
);

  logic signed [VAL_W:0] d_a, e_a, d_b, e_b;
  logic [VAL_W-1:0] add_rise_a, add_fall_a, add_rise_b, add_fall_b;

  always_comb begin
    d_a = $signed({frame_q[VAL_W-1], frame_q}) - $signed({adapt_q[VAL_W-1], adapt_q});
    e_a = $signed({adapt_q[VAL_W-1], adapt_q}) - $signed({frame_q[VAL_W-1], frame_q});
    d_b = $signed({frame_q[VAL_W-1], frame_q}) - $signed({base_q[VAL_W-1], base_q});
    e_b = $signed({base_q[VAL_W-1], base_q}) - $signed({frame_q[VAL_W-1], frame_q});
    // a bin counts only when one side leads by more than one
    add_rise_a = (d_a > 17'sd1) ? d_a[VAL_W-1:0] : '0;
    add_fall_a = (e_a > 17'sd1) ? e_a[VAL_W-1:0] : '0;
    add_rise_b = (d_b > 17'sd1) ? d_b[VAL_W-1:0] : '0;
    add_fall_b = (e_b > 17'sd1) ? e_b[VAL_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      sums <= '0;
    end else if (en) begin
      sums.rise      <= sums.rise + add_rise_a;
      sums.fall      <= sums.fall + add_fall_a;
      sums.rise_base <= sums.rise_base + add_rise_b;
      sums.fall_base <= sums.fall_base + add_fall_b;
    end
  end

endmodule

`default_nettype wire

@@ design/sbac_gate.sv @@
// Gate chain of a decide item: arm, temperature drift, hard and soft limits.
// Pure logic; the caller registers the outcome. Uses sbac_pkg.
`default_nettype none

module sbac_gate
  import sbac_pkg::*;
(
  input  wire cfg_t                    cfg,
  input  wire decide_t                 item,
  input  wire sums_t                   sums,
  input  wire logic signed [VAL_W-1:0] temp_ref,
  output logic             [OUTC_W-1:0] outcome,
  output logic                          adopt
);

  logic signed [VAL_W:0] drift, band, fdd, bdd, hl, sl, mc;
  logic signed [VAL_W:0] fd, bd, ri, fa, rib, fab;
  logic gate_a, gate_b;

  always_comb begin
    drift = $signed({temp_ref[VAL_W-1], temp_ref})
          - $signed({item.temperature[VAL_W-1], item.temperature});
    fd    = $signed({item.frame_diff[VAL_W-1], item.frame_diff});
    bd    = $signed({item.base_diff[VAL_W-1], item.base_diff});
    fdd   = fd - $signed({item.frame_diff_alt[VAL_W-1], item.frame_diff_alt});
    bdd   = bd - $signed({item.base_diff_alt[VAL_W-1], item.base_diff_alt});
    band  = $signed({{(VAL_W+1-BAND_W){1'b0}}, cfg.temp_band});
    hl    = $signed({{(VAL_W+1-LIM_W){1'b0}}, cfg.hard_limit});
    sl    = $signed({{(VAL_W+1-LIM_W){1'b0}}, cfg.soft_limit});
    mc    = $signed({{(VAL_W+1-LIM_W){1'b0}}, cfg.min_change});
    ri    = $signed({sums.rise[VAL_W-1], sums.rise});
    fa    = $signed({sums.fall[VAL_W-1], sums.fall});
    rib   = $signed({sums.rise_base[VAL_W-1], sums.rise_base});
    fab   = $signed({sums.fall_base[VAL_W-1], sums.fall_base});

    gate_a = (fd <= sl) && (fdd <= sl) && (ri <= sl) && (fa <= sl) && ((fd > mc) || (fdd > mc));
    gate_b = (bd <= sl) && (bdd <= sl) && (rib <= sl) && (fab <= sl)
          && ((bd > mc) || (bdd > mc));

    if (!item.armed) begin
      outcome = OUT_UNARMED;
    end else if ((drift < band) && (drift > -band)) begin
      outcome = OUT_TEMP_STBL;
    end else if ((fd > hl) || (fdd > hl)) begin
      outcome = OUT_DIFF_HARD;
    end else if ((ri > hl) || (fa > hl)) begin
      outcome = OUT_ADAPT_HARD;
    end else if ((rib > hl) || (fab > hl)) begin
      outcome = OUT_BASE_HARD;
    end else if (gate_a) begin
      outcome = OUT_ADOPT_A;
    end else if (gate_b) begin
      outcome = OUT_ADOPT_B;
    end else begin
      outcome = OUT_NONE;
    end
    adopt = (outcome == OUT_ADOPT_A) || (outcome == OUT_ADOPT_B);
  end

endmodule

`default_nettype wire

@@ design/spectrum_background_adapt_check.sv @@
// Top level of the spectrum background adaptation check: sequencer, registers, result stage.
// Instantiates sbac_bin_store, sbac_accum and sbac_gate. Uses sbac_pkg.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    s_tdata, s_tuser (mode)
//   m_*       out        m_tvalid / m_tready    m_tdata
//   cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load item goes from acceptance to the finish state, then to the result register.
// A decide item reads min(COMPARE_BINS, FRAME_BINS) bins, one bin per cycle through the
// memory read port, then gates; on adoption it copies min(FRAME_BINS, 32) frame bins.
// One item is worked at a time; s_tready is high only while the sequencer is idle.
// The result register holds a finished item while the next one is accepted.
// Reset clears control state, references and config registers; bin memories stay undefined.
`default_nettype none

module spectrum_background_adapt_check
  import sbac_pkg::*;
#(
  parameter int FRAME_BINS   = DEF_FRAME_BINS,
  parameter int COMPARE_BINS = DEF_COMPARE_BINS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // index, value, frame_diff, frame_diff_alt, base_diff, base_diff_alt,
  // temperature, vptat, armed; 2 pad bits
  input  wire logic [119:0]          s_tdata,
  // mode
  input  wire logic [MODE_W-1:0]     s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // adopted, outcome, rise_sum, fall_sum, rise_sum_base, fall_sum_base,
  // temp_ref_out, vptat_ref_out; 3 pad bits
  output logic      [103:0]          m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(FRAME_BINS);
  localparam int NCMP   = (COMPARE_BINS < FRAME_BINS) ? COMPARE_BINS : FRAME_BINS;
  // bins past the index range are never written, so the copy stops there
  localparam int COPY_N = (FRAME_BINS < WRITE_SPAN) ? FRAME_BINS : WRITE_SPAN;
  localparam int CNT_W  = $clog2(COPY_N + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_GATE   = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [ADDR_W-1:0] addr_d;
  logic issue, issue_d;
  logic s_acc, load_acc, decide_acc, idx_ok, commit;

  logic [IDX_W-1:0] s_index;
  logic [VAL_W-1:0] s_value;
  decide_t s_item, item;
  logic is_decide;

  cfg_t cfg;
  logic signed [VAL_W-1:0] temp_ref, vptat_ref;

  store_we_t we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [VAL_W-1:0] adapt_wdata, frame_q, adapt_q, base_q;
  sums_t sums;
  logic [OUTC_W-1:0] gate_outcome, outcome;
  logic gate_adopt;

  logic out_adopted;
  logic [OUTC_W-1:0] out_outcome;
  sums_t out_sums;
  logic [VAL_W-1:0] out_tref, out_vref;

  assign s_index = s_tdata[4:0];
  assign s_value = s_tdata[20:5];
  assign s_item.frame_diff     = s_tdata[36:21];
  assign s_item.frame_diff_alt = s_tdata[52:37];
  assign s_item.base_diff      = s_tdata[68:53];
  assign s_item.base_diff_alt  = s_tdata[84:69];
  assign s_item.temperature    = s_tdata[100:85];
  assign s_item.vptat          = s_tdata[116:101];
  assign s_item.armed          = s_tdata[117];

  assign s_tready   = (state == ST_IDLE);
  assign s_acc      = s_tvalid && s_tready;
  assign decide_acc = s_acc && (s_tuser == MODE_DECIDE);
  assign load_acc   = s_acc && (s_tuser != MODE_DECIDE);
  assign idx_ok     = (32'(s_index) < FRAME_BINS);
  assign commit     = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign cfg_ready  = 1'b1;

  assign issue = ((state == ST_SUM) && (cnt < CNT_W'(NCMP)))
              || ((state == ST_COPY) && (cnt < CNT_W'(COPY_N)));
  assign raddr = ADDR_W'(cnt);

  always_comb begin
    we.frame    = load_acc && idx_ok && (s_tuser == MODE_FRAME);
    we.base     = load_acc && idx_ok && (s_tuser == MODE_BASE);
    we.adapt    = (load_acc && idx_ok && (s_tuser == MODE_ADAPT))
               || ((state == ST_COPY) && issue_d);
    waddr       = (state == ST_COPY) ? addr_d : ADDR_W'(s_index);
    adapt_wdata = (state == ST_COPY) ? frame_q : s_value;
  end

  sbac_bin_store #(
    .FRAME_BINS(FRAME_BINS)
  ) u_store (
    .clk        (clk),
    .we         (we),
    .waddr      (waddr),
    .wdata      (s_value),
    .adapt_wdata(adapt_wdata),
    .rd_en      (issue),
    .raddr      (raddr),
    .frame_q    (frame_q),
    .adapt_q    (adapt_q),
    .base_q     (base_q)
  );

  sbac_accum u_accum (
    .clk    (clk),
    .clr    (decide_acc),
    .en     (issue_d && (state == ST_SUM)),
    .frame_q(frame_q),
    .adapt_q(adapt_q),
    .base_q (base_q),
    .sums   (sums)
  );

  sbac_gate u_gate (
    .cfg     (cfg),
    .item    (item),
    .sums    (sums),
    .temp_ref(temp_ref),
    .outcome (gate_outcome),
    .adopt   (gate_adopt)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (decide_acc) begin
          state_next = ST_SUM;
        end else if (load_acc) begin
          state_next = ST_FINISH;
        end
      end
      ST_SUM: begin
        // last bin accumulates on this edge
        if (cnt == CNT_W'(NCMP)) begin
          state_next = ST_GATE;
        end
      end
      ST_GATE: begin
        state_next = gate_adopt ? ST_COPY : ST_FINISH;
      end
      ST_COPY: begin
        if (cnt == CNT_W'(COPY_N)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      issue_d   <= 1'b0;
      temp_ref  <= '0;
      vptat_ref <= '0;
      m_tvalid  <= 1'b0;
      cfg.temp_band  <= RST_TEMP_BAND;
      cfg.hard_limit <= RST_HARD_LIMIT;
      cfg.soft_limit <= RST_SOFT_LIMIT;
      cfg.min_change <= RST_MIN_CHANGE;
    end else begin
      state   <= state_next;
      issue_d <= issue;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end else if (state != state_next) begin
        cnt <= '0;
      end
      if ((state == ST_GATE) && gate_adopt) begin
        temp_ref  <= item.temperature;
        vptat_ref <= item.vptat;
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP_BAND:  cfg.temp_band  <= cfg_data[BAND_W-1:0];
          CFG_HARD_LIMIT: cfg.hard_limit <= cfg_data[LIM_W-1:0];
          CFG_SOFT_LIMIT: cfg.soft_limit <= cfg_data[LIM_W-1:0];
          CFG_MIN_CHANGE: cfg.min_change <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_d <= raddr;
    if (s_acc) begin
      item      <= s_item;
      is_decide <= (s_tuser == MODE_DECIDE);
    end
    if (state == ST_GATE) begin
      outcome <= gate_outcome;
    end
    if (commit) begin
      out_adopted <= is_decide && ((outcome == OUT_ADOPT_A) || (outcome == OUT_ADOPT_B));
      out_outcome <= is_decide ? outcome : OUT_LOAD;
      out_sums    <= is_decide ? sums : '0;
      out_tref    <= temp_ref;
      out_vref    <= vptat_ref;
    end
  end

  assign m_tdata = {3'b000, out_vref, out_tref, out_sums.fall_base, out_sums.rise_base,
                    out_sums.fall, out_sums.rise, out_outcome, out_adopted};

  // a background write outside an accepted load belongs to the frame copy
  assert property (@(posedge clk) disable iff (rst)
    (we.adapt && !s_acc) |-> (state == ST_COPY))
    else $error("adaptive write outside copy");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_GATE && gate_adopt) |=> (state == ST_COPY))
    else $error("adoption did not start the copy");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result posted outside finish");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_adopted) |-> (out_outcome == OUT_ADOPT_A || out_outcome == OUT_ADOPT_B))
    else $error("adopted flag without adopting outcome");

  assert property (@(posedge clk) disable iff (rst)
    (cnt <= CNT_W'(COPY_N)))
    else $error("bin counter overran");

endmodule

`default_nettype wire

@@ bench/spectrum_background_adapt_check_test.sv @@
// Self-checking bench for spectrum_background_adapt_check: stream stimulus, register writes,
// and a class that mirrors the bin stores and gate chain to predict every result item.
// Depends on sbac_pkg and the spectrum_background_adapt_check RTL.
`timescale 1ns / 100ps

module spectrum_background_adapt_check_test;
  import sbac_pkg::*;

  localparam int COMPARE_SPAN   = (DEF_COMPARE_BINS < DEF_FRAME_BINS) ?
                                  DEF_COMPARE_BINS : DEF_FRAME_BINS;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEM_TARGET    = 1950;
  localparam int PHASES         = 8;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] fd;
    logic signed [VAL_W-1:0] fda;
    logic signed [VAL_W-1:0] bd;
    logic signed [VAL_W-1:0] bda;
    logic signed [VAL_W-1:0] temperature;
    logic signed [VAL_W-1:0] vptat;
    logic                    armed;
  } spectrum_item_t;

  typedef struct {
    logic                    adopted;
    logic [OUTC_W-1:0]       outcome;
    logic signed [VAL_W-1:0] rise;
    logic signed [VAL_W-1:0] fall;
    logic signed [VAL_W-1:0] rise_base;
    logic signed [VAL_W-1:0] fall_base;
    logic signed [VAL_W-1:0] temp_ref;
    logic signed [VAL_W-1:0] vptat_ref;
  } verdict_t;

  class background_mirror;
    logic signed [VAL_W-1:0] frame[DEF_FRAME_BINS];
    logic signed [VAL_W-1:0] adapt_bg[DEF_FRAME_BINS];
    logic signed [VAL_W-1:0] base_bg[DEF_FRAME_BINS];
    logic signed [VAL_W-1:0] temp_ref;
    logic signed [VAL_W-1:0] vptat_ref;
    logic [BAND_W-1:0]       temp_band;
    logic [LIM_W-1:0]        hard_limit;
    logic [LIM_W-1:0]        soft_limit;
    logic [LIM_W-1:0]        min_change;
    verdict_t                pending_verdicts[$];
    int                      errors;

    function new();
      foreach (frame[i]) begin
        frame[i] = '0;
        adapt_bg[i] = '0;
        base_bg[i] = '0;
      end
      temp_ref = '0;
      vptat_ref = '0;
      temp_band = RST_TEMP_BAND;
      hard_limit = RST_HARD_LIMIT;
      soft_limit = RST_SOFT_LIMIT;
      min_change = RST_MIN_CHANGE;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int data);
      case (idx)
        CFG_TEMP_BAND:  temp_band = data[BAND_W-1:0];
        CFG_HARD_LIMIT: hard_limit = data[LIM_W-1:0];
        CFG_SOFT_LIMIT: soft_limit = data[LIM_W-1:0];
        CFG_MIN_CHANGE: min_change = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // rises (frame above background by more than one) or falls, wrapped to 16 bits
    function logic signed [VAL_W-1:0] bin_total(bit rising, bit vs_base);
      logic [VAL_W-1:0] acc;
      int a, b;
      acc = '0;
      for (int i = 0; i < COMPARE_SPAN; i++) begin
        a = frame[i];
        b = vs_base ? base_bg[i] : adapt_bg[i];
        if (rising && a > b + 1) acc = acc + (a - b);
        if (!rising && a + 1 < b) acc = acc + (b - a);
      end
      return acc;
    endfunction

    function void take_item(spectrum_item_t it);
      verdict_t v;
      int hl, sl, mc, tb, drift, fd, fdd, bd, bdd, ri, fa, rib, fab;
      v.adopted = 1'b0;
      v.outcome = OUT_LOAD;
      v.rise = '0;
      v.fall = '0;
      v.rise_base = '0;
      v.fall_base = '0;
      if (it.mode != MODE_DECIDE) begin
        case (it.mode)
          MODE_BASE:  base_bg[it.index] = it.value;
          MODE_ADAPT: adapt_bg[it.index] = it.value;
          default:    frame[it.index] = it.value;
        endcase
      end else begin
        hl = hard_limit;
        sl = soft_limit;
        mc = min_change;
        tb = temp_band;
        drift = int'(temp_ref) - int'(it.temperature);
        fd = it.fd;
        bd = it.bd;
        fdd = fd - int'(it.fda);
        bdd = bd - int'(it.bda);
        v.rise = bin_total(1'b1, 1'b0);
        v.fall = bin_total(1'b0, 1'b0);
        v.rise_base = bin_total(1'b1, 1'b1);
        v.fall_base = bin_total(1'b0, 1'b1);
        ri = v.rise;
        fa = v.fall;
        rib = v.rise_base;
        fab = v.fall_base;
        if (!it.armed) v.outcome = OUT_UNARMED;
        else if (drift < tb && drift > -tb) v.outcome = OUT_TEMP_STBL;
        else if (fd > hl || fdd > hl) v.outcome = OUT_DIFF_HARD;
        else if (ri > hl || fa > hl) v.outcome = OUT_ADAPT_HARD;
        else if (rib > hl || fab > hl) v.outcome = OUT_BASE_HARD;
        else if (fd <= sl && fdd <= sl && ri <= sl && fa <= sl && (fd > mc || fdd > mc))
          v.outcome = OUT_ADOPT_A;
        else if (bd <= sl && bdd <= sl && rib <= sl && fab <= sl && (bd > mc || bdd > mc))
          v.outcome = OUT_ADOPT_B;
        else v.outcome = OUT_NONE;
        if (v.outcome == OUT_ADOPT_A || v.outcome == OUT_ADOPT_B) begin
          adapt_bg = frame;
          temp_ref = it.temperature;
          vptat_ref = it.vptat;
          v.adopted = 1'b1;
        end
      end
      v.temp_ref = temp_ref;
      v.vptat_ref = vptat_ref;
      pending_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        if (errors < 10) $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [103:0] d);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        if (errors < 10) $display("%0t: result item with none expected: %h", $time, d);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        compare_field("adopted", v.adopted, d[0]);
        compare_field("outcome", v.outcome, d[4:1]);
        compare_field("rise_sum", v.rise, $signed(d[20:5]));
        compare_field("fall_sum", v.fall, $signed(d[36:21]));
        compare_field("rise_sum_base", v.rise_base, $signed(d[52:37]));
        compare_field("fall_sum_base", v.fall_base, $signed(d[68:53]));
        compare_field("temp_ref_out", v.temp_ref, $signed(d[84:69]));
        compare_field("vptat_ref_out", v.vptat_ref, $signed(d[100:85]));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [119:0]          s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = MODE_BASE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [103:0]          m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEMP_BAND;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  background_mirror mirror = new();
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  tready_hold = 0;
  bit  stall_on = 1'b1;
  bit  calm = 1'b0;
  logic signed [VAL_W-1:0] seed_bins[DEF_FRAME_BINS];

  spectrum_background_adapt_check dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (tready_hold > 0) begin
      tready_hold--;
      m_tready <= 1'b0;
    end else if (!calm && stall_on && $urandom_range(0, 3) == 0) begin
      tready_hold = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.match_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("spectrum_background_adapt_check_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VAL_W-1:0] near(int center, int spread);
    return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic spectrum_item_t make_load(logic [MODE_W-1:0] mode, int idx, int val);
    spectrum_item_t it;
    it.mode = mode;
    it.index = idx[IDX_W-1:0];
    it.value = 16'(val);
    it.fd = 16'($urandom);
    it.fda = 16'($urandom);
    it.bd = 16'($urandom);
    it.bda = 16'($urandom);
    it.temperature = 16'($urandom);
    it.vptat = 16'($urandom);
    it.armed = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic spectrum_item_t make_decide(bit armed, int temp, int fd, int fda,
                                                 int bd, int bda, int vptat);
    spectrum_item_t it;
    it.mode = MODE_DECIDE;
    it.index = $urandom_range(0, WRITE_SPAN - 1);
    it.value = 16'($urandom);
    it.fd = 16'(fd);
    it.fda = 16'(fda);
    it.bd = 16'(bd);
    it.bda = 16'(bda);
    it.temperature = 16'(temp);
    it.vptat = 16'(vptat);
    it.armed = armed;
    return it;
  endfunction

  function automatic spectrum_item_t make_noise();
    spectrum_item_t it;
    it = make_load(MODE_BASE, $urandom_range(0, WRITE_SPAN - 1), $urandom);
    it.mode = $urandom_range(0, 3);
    return it;
  endfunction

  // mostly values around the gate thresholds, sometimes anything
  function automatic logic signed [VAL_W-1:0] pick_diff();
    int r;
    int marks[6];
    r = $urandom_range(0, 19);
    marks = '{mirror.soft_limit, mirror.soft_limit + 1, mirror.min_change,
              mirror.min_change + 1, mirror.hard_limit, mirror.hard_limit + 1};
    if (r < 11) return near(15, 25);
    if (r < 17) return 16'(marks[$urandom_range(0, 5)]);
    return 16'($urandom);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_temperature();
    int r, band, drift;
    r = $urandom_range(0, 9);
    band = mirror.temp_band;
    if (r < 3) drift = (band == 0) ? 0 : int'($urandom_range(0, 2 * band - 2)) - (band - 1);
    else if (r < 9) drift = (band + int'($urandom_range(0, 40))) * ($urandom_range(0, 1) ? 1 : -1);
    else return 16'($urandom);
    return 16'(int'(mirror.temp_ref) - drift);
  endfunction

  task automatic push_item(spectrum_item_t it);
    int gap;
    gap = (stall_on && !calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.mode;
    s_tdata <= {2'b00, it.armed, it.vptat, it.temperature, it.bda, it.bd, it.fda, it.fd,
                it.value, it.index};
    do @(posedge clk); while (!s_tready);
    mirror.take_item(it);
    items_sent++;
  endtask

  // holds the sender until every result is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (mirror.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    mirror.set_reg(idx, data);
  endtask

  task automatic apply_setting(int band, int hl, int sl, int mc);
    settle();
    write_reg(CFG_TEMP_BAND, band);
    write_reg(CFG_HARD_LIMIT, hl);
    write_reg(CFG_SOFT_LIMIT, sl);
    write_reg(CFG_MIN_CHANGE, mc);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a few frame bins near the background, occasional store repairs, then a decide
  task automatic measurement_cycle();
    int k, bin, spread;
    k = $urandom_range(0, 4);
    repeat (k) begin
      bin = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEF_FRAME_BINS - 1)
                                        : $urandom_range(0, COMPARE_SPAN - 1);
      spread = ($urandom_range(0, 3) == 0) ? 60 : 12;
      push_item(make_load(MODE_FRAME, bin, near(mirror.adapt_bg[bin], spread)));
    end
    if ($urandom_range(0, 3) == 0) begin
      bin = $urandom_range(0, COMPARE_SPAN - 1);
      push_item(make_load(MODE_BASE, bin, near(mirror.frame[bin], 10)));
    end
    if ($urandom_range(0, 6) == 0) begin
      bin = $urandom_range(0, COMPARE_SPAN - 1);
      push_item(make_load(MODE_ADAPT, bin, near(mirror.frame[bin], 10)));
    end
    push_item(make_decide($urandom_range(0, 9) != 0, pick_temperature(), pick_diff(),
                          ($urandom_range(0, 2) != 0) ? near(0, 10) : pick_diff(),
                          pick_diff(),
                          ($urandom_range(0, 2) != 0) ? near(0, 10) : pick_diff(),
                          $urandom));
  endtask

  initial begin
    int phase_end;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every bin of every store starts equal so early decides see zero sums
    foreach (seed_bins[i]) seed_bins[i] = near(0, 1000);
    foreach (seed_bins[i]) begin
      push_item(make_load(MODE_BASE, i, seed_bins[i]));
      push_item(make_load(MODE_ADAPT, i, seed_bins[i]));
      push_item(make_load(MODE_FRAME, i, seed_bins[i]));
    end

    // directed walk through the gate chain at reset register values
    push_item(make_decide(1'b0, 0, 0, 0, 0, 0, 0));
    push_item(make_decide(1'b1, 0, 0, 0, 0, 0, 0));
    push_item(make_decide(1'b1, -32768, 32767, 0, 0, 0, 0));        // full drift, diff hard
    push_item(make_decide(1'b1, 8, 0, -32768, 0, 0, 0));            // drift at band edge
    push_item(make_decide(1'b1, 100, 0, 0, 0, 0, 0));
    push_item(make_load(MODE_FRAME, 0, seed_bins[0] + 2));
    push_item(make_load(MODE_FRAME, 1, seed_bins[1] - 1));          // step of one is ignored
    push_item(make_decide(1'b1, 100, 10, 0, 0, 0, -32768));
    push_item(make_load(MODE_FRAME, 2, seed_bins[2] + 100));
    push_item(make_decide(1'b1, 0, 0, 0, 0, 0, 5));
    push_item(make_load(MODE_FRAME, 2, seed_bins[2]));
    push_item(make_load(MODE_BASE, 4, seed_bins[4] + 500));
    push_item(make_decide(1'b1, 0, 0, 0, 0, 0, 5));
    push_item(make_load(MODE_BASE, 4, seed_bins[4]));
    push_item(make_decide(1'b1, -100, 0, 0, 12, 0, 32767));
    push_item(make_load(MODE_FRAME, 5, 32767));
    push_item(make_load(MODE_ADAPT, 5, -32768));                    // rise sum wraps negative
    push_item(make_decide(1'b1, 100, 0, 0, 0, 0, 0));
    push_item(make_load(MODE_ADAPT, 5, seed_bins[5]));
    push_item(make_load(MODE_FRAME, 5, seed_bins[5]));
    push_item(make_load(MODE_BASE, 31, -32768));
    push_item(make_load(MODE_ADAPT, 31, 32767));
    push_item(make_load(MODE_FRAME, 31, seed_bins[31]));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(RST_TEMP_BAND, RST_HARD_LIMIT, RST_SOFT_LIMIT, RST_MIN_CHANGE);
        1: apply_setting(0, 32767, 32767, 0);
        2: apply_setting(255, 0, 0, 0);
        3: apply_setting(20, 200, 100, 10);
        4: apply_setting($urandom_range(0, 30), $urandom_range(0, 100),
                         $urandom_range(0, 60), $urandom_range(0, 30));
        5: apply_setting(1, 64, 48, 4);
        6: apply_setting($urandom_range(0, 255), $urandom_range(0, 32767),
                         $urandom_range(0, 32767), $urandom_range(0, 32767));
        default: apply_setting(4, 32, 16, 32767);
      endcase
      calm = (p == PHASES - 1);
      // spread what is left of the item budget over the remaining phases
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (PHASES - p);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 29) == 0) stall_on = !stall_on;
        if (!calm && $urandom_range(0, 49) == 0) settle();
        if ($urandom_range(0, 4) == 0) push_item(make_noise());
        else measurement_cycle();
      end
    end

    settle();
    if (mirror.errors == 0 && mirror.pending_verdicts.size() == 0) begin
      $display("spectrum_background_adapt_check_test: clean");
    end else begin
      $display("spectrum_background_adapt_check_test: errors");
    end
    $finish;
  end

endmodule
